// ===== design/ldw_pkg.sv =====
// ldw_pkg: shared widths, constants, register codes and types for the
// landing detector window core. Depends on nothing.
package ldw_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);

    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    localparam int ALT_W = 18;
    localparam int HS_W  = 13;
    localparam int VS_W  = 14;
    localparam int HAG_W = 18;

    localparam int LIM_W   = 17;
    localparam int SPD_W   = 13;
    localparam int XYS_W   = 7;
    localparam int Z_W     = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int DELTA_W  = 34;
    localparam int MAG_W    = 33;
    localparam int CM_MUL   = 11112;
    localparam int CM_DIV   = 10000;
    localparam int MUL_W    = 14;
    localparam int PROD_W   = MAG_W + MUL_W;
    localparam int CM_W     = 31;
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;

    // reciprocal of the centimetre divisor, exact floor for MAG_W-bit inputs
    localparam int          CM_SHIFT = 44;
    localparam logic [63:0] CM_RECIP =
        ((64'(CM_MUL) << CM_SHIFT) + 64'(CM_DIV - 1)) / 64'(CM_DIV);
    localparam int          RCP_LO_W = 23;
    localparam int          RCP_HI_W = 22;

    localparam int XY_SUM_W   = ROOT_W + AW;
    localparam int XY_CMP_W   = XY_SUM_W + 4;
    localparam int XY_SUM_MUL = 9;
    localparam int XY_SPD_MUL = 250 * DEPTH;
    localparam int ALT_SUM_W  = ALT_W + AW;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAKEOFF_ALT,
        REG_ABOVE_TAKEOFF,
        REG_ABOVE_GROUND,
        REG_HSPEED_LIM,
        REG_VSPEED_LIM,
        REG_XY_SPEED,
        REG_Z_LIMIT
    } cfg_reg_t;

    typedef struct packed {
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        logic [ALT_W-1:0] alt;
        logic [HS_W-1:0]  hs;
        logic [VS_W-1:0]  vs;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_CENTRE,
        ST_RD,
        ST_DELTA,
        ST_MUL,
        ST_DIV,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

// ===== design/ldw_ram.sv =====
// ldw_ram: generic single-write, single-read synchronous memory with
// registered read data. No dependencies.
module ldw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ===== design/ldw_cdiv.sv =====
// ldw_cdiv: centimetre scaling of a delta magnitude, floor(m * 11112 / 10000),
// by reciprocal multiplication in two halves; the partial products are
// registered, then the shifted quotient with done. Depends on ldw_pkg.
module ldw_cdiv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ldw_pkg::MAG_W-1:0]  magnitude,
    output logic                       done,
    output logic [ldw_pkg::PROD_W-1:0] quotient
);
    import ldw_pkg::*;

    localparam int LO_P_W = MAG_W + RCP_LO_W;
    localparam int HI_P_W = MAG_W + RCP_HI_W;
    localparam int SUM_W  = MAG_W + RCP_LO_W + RCP_HI_W;

    localparam logic [RCP_LO_W-1:0] RCP_LO = CM_RECIP[RCP_LO_W-1:0];
    localparam logic [RCP_HI_W-1:0] RCP_HI = CM_RECIP[RCP_LO_W+RCP_HI_W-1:RCP_LO_W];

    logic [LO_P_W-1:0] lo_reg;
    logic [HI_P_W-1:0] hi_reg;
    logic [SUM_W-1:0]  scaled;
    logic [PROD_W-1:0] quo_reg;
    logic              prod_ok_reg, done_reg;

    always_comb
    begin
        scaled = (SUM_W'(hi_reg) << RCP_LO_W) + SUM_W'(lo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ok_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            prod_ok_reg <= start;
            done_reg    <= prod_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg <= LO_P_W'(magnitude) * LO_P_W'(RCP_LO);
            hi_reg <= HI_P_W'(magnitude) * HI_P_W'(RCP_HI);
        end
        if (prod_ok_reg)
        begin
            quo_reg <= PROD_W'(scaled >> CM_SHIFT);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== design/ldw_isqrt.sv =====
// ldw_isqrt: truncated integer square root, two radicand bits per cycle.
// Depends on ldw_pkg.
module ldw_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ldw_pkg::RAD_W-1:0]  radicand,
    output logic                      done,
    output logic [ldw_pkg::ROOT_W-1:0] root
);
    import ldw_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg, ge;
    logic [TRY_W-1:0]  trial_rem, trial;

    always_comb
    begin
        trial_rem = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = trial_rem >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(trial_rem - trial) : REM_W'(trial_rem);
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== design/landing_detector_window_core.sv =====
// landing_detector_window_core: top level of the landing detector window.
// Depends on ldw_pkg, ldw_ram, ldw_cdiv and ldw_isqrt.
//
// Each accepted fix is written to a ring of DEPTH fixes held in one
// synchronous memory, then evaluated; one result transaction follows every
// fix. A fix that fails the altitude or height tests, or arrives before the
// ring is full, goes straight to the output state. Otherwise a scan pass
// (a read and an accumulate state per entry) checks the speeds and sums the
// ring; if no speed is over its limit, a second pass handles one entry at a
// time through the reciprocal centimetre scaling and the square root.
// in_stall is high while a fix is in work.
// The ring needs no clearing pass; the register port is always ready.
module landing_detector_window_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ldw_pkg::LAT_W-1:0]       latitude,
    input  logic [ldw_pkg::LON_W-1:0]       longitude,
    input  logic [ldw_pkg::ALT_W-1:0]       altitude,
    input  logic [ldw_pkg::HS_W-1:0]        horizontal_speed,
    input  logic [ldw_pkg::VS_W-1:0]        vertical_speed,
    input  logic [ldw_pkg::HAG_W-1:0]       height_above_ground,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            flight_end,
    output logic                            at_ground,
    output logic                            above_takeoff,
    output logic                            far_from_ground,
    output logic                            low_hspeed,
    output logic                            low_vspeed,
    output logic                            window_full,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ldw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ldw_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ldw_pkg::*;

    // configuration
    logic [ALT_W-1:0] takeoff_reg;
    logic [LIM_W-1:0] above_takeoff_reg, above_ground_reg;
    logic [SPD_W-1:0] hs_lim_reg, vs_lim_reg;
    logic [XYS_W-1:0] xy_speed_reg;
    logic [Z_W-1:0]   z_lim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            takeoff_reg       <= '0;
            above_takeoff_reg <= LIM_W'(1000);
            above_ground_reg  <= LIM_W'(500);
            hs_lim_reg        <= SPD_W'(50);
            vs_lim_reg        <= SPD_W'(50);
            xy_speed_reg      <= XYS_W'(5);
            z_lim_reg         <= Z_W'(30);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TAKEOFF_ALT:   takeoff_reg       <= cfg_data[ALT_W-1:0];
                REG_ABOVE_TAKEOFF: above_takeoff_reg <= cfg_data[LIM_W-1:0];
                REG_ABOVE_GROUND:  above_ground_reg  <= cfg_data[LIM_W-1:0];
                REG_HSPEED_LIM:    hs_lim_reg        <= cfg_data[SPD_W-1:0];
                REG_VSPEED_LIM:    vs_lim_reg        <= cfg_data[SPD_W-1:0];
                REG_XY_SPEED:      xy_speed_reg      <= cfg_data[XYS_W-1:0];
                REG_Z_LIMIT:       z_lim_reg         <= cfg_data[Z_W-1:0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic   accept, last_idx, out_load, div_start, root_start;
    logic   div_done_x, div_done_y, root_done;

    logic [AW-1:0] slot_reg, idx_reg;
    logic full_reg, high_reg, far_reg, slow_h_reg, slow_v_reg;

    logic signed [LAT_W+AW-1:0] sum_lat_reg;
    logic signed [LON_W+AW-1:0] sum_lon_reg;
    logic signed [ALT_W+AW-1:0] sum_alt_reg;
    logic any_h_reg, any_v_reg;
    logic [LAT_W-1:0] c_lat_reg;
    logic [LON_W-1:0] c_lon_reg;
    logic [ALT_W-1:0] c_alt_reg;
    logic [MAG_W-1:0] mag_x_reg, mag_y_reg;
    logic [ALT_W-1:0] dalt_reg;
    logic [CM_W-1:0]  cm_x_reg, cm_y_reg;
    logic [2*CM_W-1:0] sqx_reg;
    logic [XY_SUM_W-1:0]  acc_xy_reg;
    logic [ALT_SUM_W-1:0] acc_alt_reg;
    logic end_reg;

    entry_t wr_entry, rd_entry;

    logic signed [ALT_W:0]   diff_alt_in, hag_ext, rd_dalt;
    logic signed [DELTA_W-1:0] d_lat, d_lon;
    logic [VS_W-1:0] vs_abs;
    logic high_now, far_now, full_now, h_fast, v_fast, stat_now;
    logic [PROD_W-1:0] quo_x, quo_y;
    logic [RAD_W-1:0]  radicand;
    logic [ROOT_W-1:0] root;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign last_idx = idx_reg == AW'(DEPTH - 1);
    assign wr_entry = '{lat: latitude, lon: longitude, alt: altitude,
                        hs: horizontal_speed, vs: vertical_speed};

    ldw_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (slot_reg),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    always_comb
    begin
        diff_alt_in = $signed({altitude[ALT_W-1], altitude})
                    - $signed({takeoff_reg[ALT_W-1], takeoff_reg});
        hag_ext     = $signed({height_above_ground[HAG_W-1], height_above_ground});
        high_now    = diff_alt_in > $signed({2'b00, above_takeoff_reg});
        far_now     = hag_ext > $signed({2'b00, above_ground_reg});
        full_now    = full_reg || (slot_reg == AW'(DEPTH - 1));

        vs_abs = rd_entry.vs[VS_W-1] ? VS_W'(-rd_entry.vs) : rd_entry.vs;
        h_fast = rd_entry.hs > hs_lim_reg;
        v_fast = vs_abs > {1'b0, vs_lim_reg};

        d_lat = $signed({{(DELTA_W-LAT_W){c_lat_reg[LAT_W-1]}}, c_lat_reg})
              - $signed({{(DELTA_W-LAT_W){rd_entry.lat[LAT_W-1]}}, rd_entry.lat});
        d_lon = $signed({{(DELTA_W-LON_W){c_lon_reg[LON_W-1]}}, c_lon_reg})
              - $signed({{(DELTA_W-LON_W){rd_entry.lon[LON_W-1]}}, rd_entry.lon});
        rd_dalt = $signed({c_alt_reg[ALT_W-1], c_alt_reg})
                - $signed({rd_entry.alt[ALT_W-1], rd_entry.alt});

        radicand = RAD_W'(sqx_reg) + RAD_W'(RAD_W'(cm_y_reg) * RAD_W'(cm_y_reg));

        stat_now = (XY_CMP_W'(acc_xy_reg) * XY_CMP_W'(XY_SUM_MUL))
                       < (XY_CMP_W'(xy_speed_reg) * XY_CMP_W'(XY_SPD_MUL))
                && (acc_alt_reg < ALT_SUM_W'({z_lim_reg, AW'(0)}));
    end

    ldw_cdiv u_div_x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .magnitude(mag_x_reg),
        .done(div_done_x), .quotient(quo_x)
    );

    ldw_cdiv u_div_y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .magnitude(mag_y_reg),
        .done(div_done_y), .quotient(quo_y)
    );

    ldw_isqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(root_start), .radicand(radicand),
        .done(root_done), .root(root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (high_now || far_now || !full_now) ? ST_OUT : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_ACC;
            ST_SCAN_ACC: state_next = last_idx ? ST_CENTRE : ST_SCAN_RD;
            ST_CENTRE:   state_next = (any_h_reg || any_v_reg) ? ST_OUT : ST_RD;
            ST_RD:       state_next = ST_DELTA;
            ST_DELTA:    state_next = ST_MUL;
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done_x && div_done_y)
                begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX:      state_next = ST_SQY;
            ST_SQY:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = last_idx ? ST_DECIDE : ST_RD;
                end
            end
            ST_DECIDE:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ring pointer and sticky flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            full_reg   <= 1'b0;
            high_reg   <= 1'b0;
            far_reg    <= 1'b0;
            slow_h_reg <= 1'b1;
            slow_v_reg <= 1'b1;
        end
        else if (accept)
        begin
            slot_reg <= (slot_reg == AW'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            full_reg <= full_now;
            high_reg <= high_now;
            if (!high_now)
            begin
                far_reg <= far_now;
            end
        end
        else if (state_reg == ST_CENTRE)
        begin
            slow_h_reg <= !any_h_reg;
            if (!any_h_reg)
            begin
                slow_v_reg <= !any_v_reg;
            end
        end
    end

    // evaluation datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_reg     <= '0;
                    sum_lat_reg <= '0;
                    sum_lon_reg <= '0;
                    sum_alt_reg <= '0;
                    any_h_reg   <= 1'b0;
                    any_v_reg   <= 1'b0;
                    acc_xy_reg  <= '0;
                    acc_alt_reg <= '0;
                    end_reg     <= 1'b0;
                end
            end
            ST_SCAN_ACC:
            begin
                sum_lat_reg <= sum_lat_reg
                    + $signed({{AW{rd_entry.lat[LAT_W-1]}}, rd_entry.lat});
                sum_lon_reg <= sum_lon_reg
                    + $signed({{AW{rd_entry.lon[LON_W-1]}}, rd_entry.lon});
                sum_alt_reg <= sum_alt_reg
                    + $signed({{AW{rd_entry.alt[ALT_W-1]}}, rd_entry.alt});
                any_h_reg <= any_h_reg || h_fast;
                any_v_reg <= any_v_reg || v_fast;
                if (!last_idx)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_CENTRE:
            begin
                c_lat_reg <= LAT_W'(sum_lat_reg >>> AW);
                c_lon_reg <= LON_W'(sum_lon_reg >>> AW);
                c_alt_reg <= ALT_W'(sum_alt_reg >>> AW);
                idx_reg   <= '0;
            end
            ST_DELTA:
            begin
                mag_x_reg <= MAG_W'(d_lat[DELTA_W-1] ? -d_lat : d_lat);
                mag_y_reg <= MAG_W'(d_lon[DELTA_W-1] ? -d_lon : d_lon);
                dalt_reg  <= ALT_W'(rd_dalt[ALT_W] ? -rd_dalt : rd_dalt);
            end
            ST_DIV:
            begin
                // saturate at the largest 31-bit centimetre value
                cm_x_reg <= (quo_x > PROD_W'({CM_W{1'b1}})) ? {CM_W{1'b1}} : CM_W'(quo_x);
                cm_y_reg <= (quo_y > PROD_W'({CM_W{1'b1}})) ? {CM_W{1'b1}} : CM_W'(quo_y);
            end
            ST_SQX:
            begin
                sqx_reg <= (2*CM_W)'(cm_x_reg) * (2*CM_W)'(cm_x_reg);
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    acc_xy_reg  <= acc_xy_reg + XY_SUM_W'(root);
                    acc_alt_reg <= acc_alt_reg + ALT_SUM_W'(dalt_reg);
                    idx_reg     <= idx_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                end_reg <= stat_now;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            flight_end      <= end_reg;
            at_ground       <= !high_reg && !far_reg && slow_h_reg && slow_v_reg;
            above_takeoff   <= high_reg;
            far_from_ground <= far_reg;
            low_hspeed      <= slow_h_reg;
            low_vspeed      <= slow_v_reg;
            window_full     <= full_reg;
        end
    end
endmodule
